FILE: src/slcfp_pkg.sv
// Shared constants and types for the sync/length/checksum frame parser.
package slcfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] FRAME_TAIL  = 8'h0D;
    localparam logic [7:0] CMD_MOTOR   = 8'h01;
    localparam logic [7:0] CMD_SERVO   = 8'h02;

    localparam logic [7:0] MOTOR_MIN_LEN = 8'd4;
    localparam logic [7:0] SERVO_MIN_LEN = 8'd3;

    localparam int         KEPT_DEPTH = 3;
    localparam logic [7:0] KEPT_LIMIT = 8'(KEPT_DEPTH);

    localparam logic KIND_MOTOR = 1'b0;
    localparam logic KIND_SERVO = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SYNC2    = 3'd1,
        PH_LENGTH   = 3'd2,
        PH_COMMAND  = 3'd3,
        PH_PAYLOAD  = 3'd4,
        PH_CHECKSUM = 3'd5,
        PH_TAIL     = 3'd6
    } phase_t;

    typedef struct packed {
        logic               command_kind;
        logic [7:0]         target_id;
        logic signed [15:0] motor_speed;
        logic [7:0]         servo_angle;
    } cmd_t;

endpackage

FILE: src/slcfp_rx_if.sv
// Byte channel into the frame parser.
interface slcfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/slcfp_cmd_if.sv
// Command channel out of the frame parser.
interface slcfp_cmd_if;
    logic               valid;
    logic               ready;
    logic               command_kind;
    logic [7:0]         target_id;
    logic signed [15:0] motor_speed;
    logic [7:0]         servo_angle;

    modport source (output valid, output command_kind, output target_id,
                    output motor_speed, output servo_angle, input ready);
    modport sink   (input valid, input command_kind, input target_id,
                    input motor_speed, input servo_angle, output ready);
endinterface

FILE: src/sync_length_checksum_frame_parser.sv
// Top level of the sync/length/checksum frame parser.
// The parser takes one received byte per transaction on rx and looks for frames
// of the form 0xAA 0x55, length L, command, L payload bytes, an 8-bit additive
// checksum over every earlier frame byte (sync bytes included) and a 0x0D tail.
// A good frame with command 0x01 and L >= 4 yields a motor transaction on cmd
// (id, big-endian signed speed from payload bytes two and three); command 0x02
// with L >= 3 yields a servo transaction (id, angle). Anything else yields
// nothing and the parser goes back to hunting for 0xAA. Throughput is one byte
// per clock while the output register can load: a byte lands in the input
// register, then runs through the phase logic and the 8-bit checksum add once
// the output register can load, and any result lands in the output register
// that drives cmd. rx.ready drops only while the output register holds an
// untaken command and cmd.ready is low.
module sync_length_checksum_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    slcfp_rx_if.sink     rx,
    slcfp_cmd_if.source  cmd
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    logic            out_can_load;
    logic            advance;
    logic            rx_take;
    logic            res_valid;
    slcfp_pkg::cmd_t res;

    // the byte in the input register moves on whenever the result slot is free
    assign advance  = in_valid_reg && out_can_load;
    assign rx.ready = !in_valid_reg || out_can_load;
    assign rx_take  = rx.valid && rx.ready;

    assign in_valid_next = rx_take || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    slcfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    slcfp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .can_load (out_can_load),
        .cmd      (cmd)
    );

endmodule

FILE: src/slcfp_parser.sv
// Frame parser state machine, checksum accumulator and result decode.
module slcfp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output slcfp_pkg::cmd_t     res
);

    slcfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] chk_reg, chk_next;
    logic [7:0] kept_reg [slcfp_pkg::KEPT_DEPTH];
    logic       kept_we;
    logic [7:0] count_inc;
    logic       frame_ok;
    logic       motor_ok;
    logic       servo_ok;

    assign count_inc = count_reg + 8'd1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                slcfp_pkg::PH_SYNC2:
                    phase_next = (rx_byte == slcfp_pkg::SYNC_SECOND) ?
                                 slcfp_pkg::PH_LENGTH : slcfp_pkg::PH_IDLE;
                slcfp_pkg::PH_LENGTH:
                    phase_next = slcfp_pkg::PH_COMMAND;
                slcfp_pkg::PH_COMMAND:
                    phase_next = (length_reg == 8'd0) ?
                                 slcfp_pkg::PH_CHECKSUM : slcfp_pkg::PH_PAYLOAD;
                slcfp_pkg::PH_PAYLOAD:
                    if (count_inc >= length_reg)
                    begin
                        phase_next = slcfp_pkg::PH_CHECKSUM;
                    end
                slcfp_pkg::PH_CHECKSUM:
                    phase_next = slcfp_pkg::PH_TAIL;
                slcfp_pkg::PH_TAIL:
                    phase_next = slcfp_pkg::PH_IDLE;
                default:
                    phase_next = (rx_byte == slcfp_pkg::SYNC_FIRST) ?
                                 slcfp_pkg::PH_SYNC2 : slcfp_pkg::PH_IDLE;
            endcase
        end
    end

    // datapath updates per phase
    always_comb
    begin
        length_next  = length_reg;
        command_next = command_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        chk_next     = chk_reg;
        kept_we      = 1'b0;
        if (step)
        begin
            unique case (phase_reg)
                slcfp_pkg::PH_SYNC2:
                    if (rx_byte == slcfp_pkg::SYNC_SECOND)
                    begin
                        sum_next = sum_reg + rx_byte;
                    end
                slcfp_pkg::PH_LENGTH:
                begin
                    length_next = rx_byte;
                    sum_next    = sum_reg + rx_byte;
                end
                slcfp_pkg::PH_COMMAND:
                begin
                    command_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                    count_next   = 8'd0;
                end
                slcfp_pkg::PH_PAYLOAD:
                begin
                    kept_we    = (count_reg < slcfp_pkg::KEPT_LIMIT);
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_inc;
                end
                slcfp_pkg::PH_CHECKSUM:
                    chk_next = rx_byte;
                slcfp_pkg::PH_TAIL:
                    ;
                default:
                    if (rx_byte == slcfp_pkg::SYNC_FIRST)
                    begin
                        sum_next   = rx_byte;
                        count_next = 8'd0;
                    end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= slcfp_pkg::PH_IDLE;
            length_reg  <= 8'd0;
            command_reg <= 8'd0;
            count_reg   <= 8'd0;
            sum_reg     <= 8'd0;
            chk_reg     <= 8'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            command_reg <= command_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            chk_reg     <= chk_next;
        end
    end

    // first payload bytes only; no reset needed
    always_ff @(posedge clk)
    begin
        if (kept_we)
        begin
            kept_reg[count_reg[1:0]] <= rx_byte;
        end
    end

    // decode on the tail byte
    assign frame_ok = step && (phase_reg == slcfp_pkg::PH_TAIL)
                      && (rx_byte == slcfp_pkg::FRAME_TAIL) && (sum_reg == chk_reg);
    assign motor_ok = (command_reg == slcfp_pkg::CMD_MOTOR)
                      && (length_reg >= slcfp_pkg::MOTOR_MIN_LEN);
    assign servo_ok = (command_reg == slcfp_pkg::CMD_SERVO)
                      && (length_reg >= slcfp_pkg::SERVO_MIN_LEN);

    assign res_valid = frame_ok && (motor_ok || servo_ok);

    always_comb
    begin
        res.target_id = kept_reg[0];
        if (motor_ok)
        begin
            res.command_kind = slcfp_pkg::KIND_MOTOR;
            res.motor_speed  = {kept_reg[1], kept_reg[2]};
            res.servo_angle  = 8'd0;
        end
        else
        begin
            res.command_kind = slcfp_pkg::KIND_SERVO;
            res.motor_speed  = 16'sd0;
            res.servo_angle  = kept_reg[1];
        end
    end

endmodule

FILE: src/slcfp_out_reg.sv
// Result register driving the command channel.
module slcfp_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  slcfp_pkg::cmd_t res,
    output logic            can_load,
    slcfp_cmd_if.source     cmd
);

    logic            valid_reg, valid_next;
    slcfp_pkg::cmd_t data_reg;

    assign can_load = !valid_reg || cmd.ready;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (cmd.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign cmd.valid        = valid_reg;
    assign cmd.command_kind = data_reg.command_kind;
    assign cmd.target_id    = data_reg.target_id;
    assign cmd.motor_speed  = data_reg.motor_speed;
    assign cmd.servo_angle  = data_reg.servo_angle;

endmodule

FILE: src/slcfp_checker.sv
// Port-level checks for the frame parser, bound to the top level.
module slcfp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rx_ready,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               command_kind,
    input logic [7:0]         target_id,
    input logic signed [15:0] motor_speed,
    input logic [7:0]         servo_angle
);

    // stalled command holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(command_kind)
        && $stable(target_id) && $stable(motor_speed) && $stable(servo_angle))
        else $error("command changed while stalled");

    // unused field of each command kind is zero
    a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> ((command_kind == 1'b0) && (servo_angle == 8'd0))
                   || ((command_kind == 1'b1) && (motor_speed == 16'sd0)))
        else $error("unused command field not zero");

    // empty output slot never back-pressures the byte stream
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> rx_ready)
        else $error("rx stalled with empty output");

    // nothing shows during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !cmd_valid)
        else $error("command valid during reset");

endmodule

bind sync_length_checksum_frame_parser slcfp_checker u_slcfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_ready     (rx.ready),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .command_kind (cmd.command_kind),
    .target_id    (cmd.target_id),
    .motor_speed  (cmd.motor_speed),
    .servo_angle  (cmd.servo_angle)
);

FILE: tb/slcfp_frame_check.sv
// Frame parser checker: tracks the byte stream, predicts commands, compares them.
`timescale 1ns / 1ps

module slcfp_frame_check
    import slcfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  logic               command_kind,
    input  logic [7:0]         target_id,
    input  logic signed [15:0] motor_speed,
    input  logic [7:0]         servo_angle,
    output int                 mismatches,
    output int                 awaited,
    output int                 motor_seen,
    output int                 servo_seen
);

    // shadow of the parser state
    phase_t     ph        = PH_IDLE;
    logic [7:0] frame_len = '0;
    logic [7:0] frame_cmd = '0;
    logic [7:0] pay_cnt   = '0;
    logic [7:0] run_sum   = '0;
    logic [7:0] rx_sum    = '0;
    logic [7:0] kept [KEPT_DEPTH];

    cmd_t pending_cmds [$];
    int   err_count = 0;
    int   pend_n    = 0;
    int   n_motor   = 0;
    int   n_servo   = 0;

    assign mismatches = err_count;
    assign awaited    = pend_n;
    assign motor_seen = n_motor;
    assign servo_seen = n_servo;

    task automatic decode_rx_byte(input logic [7:0] b);
        cmd_t c;
        case (ph)
            PH_SYNC2:
            begin
                if (b == SYNC_SECOND)
                begin
                    run_sum += b;
                    ph = PH_LENGTH;
                end
                else
                begin
                    // a bad second sync byte never restarts a frame, not even 0xAA
                    ph = PH_IDLE;
                end
            end
            PH_LENGTH:
            begin
                frame_len = b;
                run_sum += b;
                ph = PH_COMMAND;
            end
            PH_COMMAND:
            begin
                frame_cmd = b;
                run_sum += b;
                pay_cnt = '0;
                ph = (frame_len == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (pay_cnt < KEPT_LIMIT)
                    kept[pay_cnt[1:0]] = b;
                run_sum += b;
                pay_cnt += 8'd1;
                if (pay_cnt >= frame_len)
                    ph = PH_CHECKSUM;
            end
            PH_CHECKSUM:
            begin
                rx_sum = b;
                ph = PH_TAIL;
            end
            PH_TAIL:
            begin
                if (b == FRAME_TAIL && run_sum == rx_sum)
                begin
                    if (frame_cmd == CMD_MOTOR && frame_len >= MOTOR_MIN_LEN)
                    begin
                        c.command_kind = KIND_MOTOR;
                        c.target_id    = kept[0];
                        c.motor_speed  = {kept[1], kept[2]};
                        c.servo_angle  = '0;
                        pending_cmds.push_back(c);
                    end
                    else if (frame_cmd == CMD_SERVO && frame_len >= SERVO_MIN_LEN)
                    begin
                        c.command_kind = KIND_SERVO;
                        c.target_id    = kept[0];
                        c.motor_speed  = '0;
                        c.servo_angle  = kept[1];
                        pending_cmds.push_back(c);
                    end
                end
                ph = PH_IDLE;
            end
            default:
            begin
                if (b == SYNC_FIRST)
                begin
                    run_sum = b;
                    pay_cnt = '0;
                    ph = PH_SYNC2;
                end
                else
                begin
                    ph = PH_IDLE;
                end
            end
        endcase
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t want;
        if (!rst_n)
        begin
            ph = PH_IDLE;
            frame_len = '0;
            frame_cmd = '0;
            pay_cnt = '0;
            run_sum = '0;
            rx_sum = '0;
            foreach (kept[i])
                kept[i] = '0;
            pending_cmds.delete();
            pend_n = 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
                decode_rx_byte(rx_byte);
            if (cmd_valid && cmd_ready)
            begin
                if (pending_cmds.size() == 0)
                begin
                    err_count++;
                    $display("%0t: no command expected, actual kind %b id %h speed %h angle %h",
                             $time, command_kind, target_id, motor_speed, servo_angle);
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    check_field("command_kind", 16'(want.command_kind), 16'(command_kind));
                    check_field("target_id", 16'(want.target_id), 16'(target_id));
                    check_field("motor_speed", want.motor_speed, motor_speed);
                    check_field("servo_angle", 16'(want.servo_angle), 16'(servo_angle));
                    if (want.command_kind == KIND_MOTOR)
                        n_motor++;
                    else
                        n_servo++;
                end
            end
            pend_n = pending_cmds.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Top of the frame parser testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import slcfp_pkg::*;

    localparam int BYTE_TARGET  = 1450;
    localparam int STILL_LIMIT  = 2000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 16;     // a command reaches cmd after its tail byte passes the input register

    // how a generated frame is spoiled, if at all
    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_TAIL,
        FLAW_SYNC2
    } flaw_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    slcfp_rx_if  rx_ch ();
    slcfp_cmd_if cmd_ch ();

    int  mismatches;
    int  awaited;
    int  motor_seen;
    int  servo_seen;
    int  bytes_sent  = 0;
    int  frames_sent = 0;
    int  still       = 0;
    bit  steady      = 1'b0;   // no idling on either side while set

    sync_length_checksum_frame_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .cmd   (cmd_ch)
    );

    slcfp_frame_check frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_ch.valid),
        .rx_ready     (rx_ch.ready),
        .rx_byte      (rx_ch.rx_byte),
        .cmd_valid    (cmd_ch.valid),
        .cmd_ready    (cmd_ch.ready),
        .command_kind (cmd_ch.command_kind),
        .target_id    (cmd_ch.target_id),
        .motor_speed  (cmd_ch.motor_speed),
        .servo_angle  (cmd_ch.servo_angle),
        .mismatches   (mismatches),
        .awaited      (awaited),
        .motor_seen   (motor_seen),
        .servo_seen   (servo_seen)
    );

    always #6 clk = ~clk;

    // Output side: cmd.ready drops about 7 percent of the time, never while steady.
    always @(negedge clk)
        cmd_ch.ready <= steady || ($urandom_range(99) >= 7);

    // Watchdog: a run that stops moving transactions is a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
                still <= 0;
            else
                still <= still + 1;
            if (still >= STILL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STILL_LIMIT);
                $display("sync_length_checksum_frame_parser: mismatch");
                $finish;
            end
        end
    end

    // Called at a falling edge, returns at the falling edge after the byte is
    // taken. valid stays high into the next byte unless an idle gap is rolled.
    task automatic send_byte(input logic [7:0] b);
        steady = (bytes_sent >= 500 && bytes_sent < 800);
        if (!steady && $urandom_range(99) < 7)
        begin
            rx_ch.valid <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
            @(negedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Sends one frame; the first three payload bytes are given, the rest random.
    task automatic send_frame(input logic [7:0] cmd_b, input logic [7:0] len,
                              input logic [7:0] p0, input logic [7:0] p1,
                              input logic [7:0] p2, input flaw_e flaw);
        logic [7:0] sum;
        logic [7:0] b;
        sum = SYNC_FIRST;
        sum += SYNC_SECOND;
        sum += len;
        sum += cmd_b;
        send_byte(SYNC_FIRST);
        if (flaw == FLAW_SYNC2)
        begin
            // half the time a repeated 0xAA, which must not restart the frame
            b = $urandom_range(1) ? SYNC_FIRST : (SYNC_SECOND ^ 8'($urandom_range(255, 1)));
            send_byte(b);
        end
        else
        begin
            send_byte(SYNC_SECOND);
        end
        send_byte(len);
        send_byte(cmd_b);
        for (int i = 0; i < int'(len); i++)
        begin
            b = (i == 0) ? p0 : (i == 1) ? p1 : (i == 2) ? p2 : 8'($urandom);
            sum += b;
            send_byte(b);
        end
        send_byte((flaw == FLAW_SUM) ? (sum ^ (8'd1 << $urandom_range(7))) : sum);
        send_byte((flaw == FLAW_TAIL) ? (FRAME_TAIL ^ 8'($urandom_range(255, 1)))
                                      : FRAME_TAIL);
        frames_sent++;
    endtask

    initial
    begin
        int         r;
        int         n;
        logic [7:0] len;
        logic [7:0] cmd_b;
        flaw_e      flaw;

        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes for both commands
        send_frame(CMD_MOTOR, MOTOR_MIN_LEN, 8'h00, 8'h80, 8'h00, FLAW_NONE);
        send_frame(CMD_MOTOR, MOTOR_MIN_LEN, 8'hFF, 8'h7F, 8'hFF, FLAW_NONE);
        send_frame(CMD_SERVO, SERVO_MIN_LEN, 8'h00, 8'hFF, 8'h00, FLAW_NONE);
        send_frame(CMD_SERVO, SERVO_MIN_LEN, 8'hFF, 8'h00, 8'hFF, FLAW_NONE);
        // zero length goes straight to the checksum, and gives nothing
        send_frame(CMD_MOTOR, 8'd0, 8'h00, 8'h00, 8'h00, FLAW_NONE);
        // one byte short of each command's minimum
        send_frame(CMD_MOTOR, MOTOR_MIN_LEN - 8'd1, 8'h11, 8'h22, 8'h33, FLAW_NONE);
        send_frame(CMD_SERVO, SERVO_MIN_LEN - 8'd1, 8'h44, 8'h55, 8'h66, FLAW_NONE);
        // unknown commands
        send_frame(8'h00, 8'd4, 8'h01, 8'h02, 8'h03, FLAW_NONE);
        send_frame(8'hFF, 8'd4, 8'h01, 8'h02, 8'h03, FLAW_NONE);
        // bad checksum, bad tail, bad second sync
        send_frame(CMD_MOTOR, 8'd4, 8'h12, 8'h34, 8'h56, FLAW_SUM);
        send_frame(CMD_SERVO, 8'd3, 8'h12, 8'h34, 8'h56, FLAW_TAIL);
        send_frame(CMD_SERVO, 8'd3, 8'h21, 8'h43, 8'h65, FLAW_SYNC2);
        // stray 0xAA right before a frame: AA AA drops the frame
        send_byte(SYNC_FIRST);
        send_frame(CMD_SERVO, 8'd3, 8'h5A, 8'hA5, 8'h00, FLAW_NONE);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        // longest payload, and payloads past the kept bytes
        send_frame(CMD_MOTOR, 8'd255, 8'hC3, 8'hFF, 8'hFE, FLAW_NONE);
        send_frame(CMD_SERVO, 8'd5, 8'h3C, 8'h99, 8'h01, FLAW_NONE);

        // Random: mostly well-formed frames with random content
        while (bytes_sent < BYTE_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                cmd_b = (r < 35) ? CMD_MOTOR : CMD_SERVO;
                n = $urandom_range(99);
                len = (n < 85) ? 8'($urandom_range(8)) :
                      (n < 98) ? 8'($urandom_range(40)) : 8'd255;
                send_frame(cmd_b, len, 8'($urandom), 8'($urandom), 8'($urandom), FLAW_NONE);
            end
            else if (r < 85)
            begin
                n = $urandom_range(2);
                cmd_b = (n == 0) ? CMD_MOTOR : (n == 1) ? CMD_SERVO : 8'($urandom);
                n = $urandom_range(2);
                flaw = (n == 0) ? FLAW_SUM : (n == 1) ? FLAW_TAIL : FLAW_SYNC2;
                send_frame(cmd_b, 8'($urandom_range(6)), 8'($urandom), 8'($urandom),
                           8'($urandom), flaw);
            end
            else if (r < 90)
            begin
                send_frame(8'($urandom), 8'($urandom_range(6)), 8'($urandom),
                           8'($urandom), 8'($urandom), FLAW_NONE);
            end
            else
            begin
                // line noise, sometimes a lone sync byte
                repeat ($urandom_range(6, 1))
                    send_byte($urandom_range(3) == 0 ? SYNC_FIRST : 8'($urandom));
            end
        end

        rx_ch.valid <= 1'b0;
        wait (awaited == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d frames, with noise and spoiled frames mixed in",
                 bytes_sent, frames_sent);
        $display("%0d motor and %0d servo commands compared", motor_seen, servo_seen);
        if (mismatches == 0)
            $display("sync_length_checksum_frame_parser: match");
        else
            $display("sync_length_checksum_frame_parser: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
src/slcfp_pkg.sv
src/slcfp_rx_if.sv
src/slcfp_cmd_if.sv
src/slcfp_parser.sv
src/slcfp_out_reg.sv
src/sync_length_checksum_frame_parser.sv
src/slcfp_checker.sv
tb/slcfp_frame_check.sv
tb/testbench.sv
